>>> hw/rtl/tpofd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Three-phase optical flow decoder package
// Shared widths, codes, reset values and types of the decoder blocks.
// ----------------------------------------------------------------------------
package tpofd_pkg;

   // Widths of the sample and of the fixed-point trackers.
   localparam int LEVEL_BITS       = 16;
   localparam int FRAC_BITS        = 16;
   localparam int PHASES_PER_LITER = 6;
   localparam int FIELD_BITS       = 16;
   localparam int CSR_BITS         = 16;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int WEIGHT_BITS      = 16;
   localparam int TRACK_BITS       = LEVEL_BITS + FRAC_BITS;
   localparam int DIFF_BITS        = LEVEL_BITS + 3;
   localparam int LITER_BITS       = 32;
   localparam int PHASE_BITS       = 3;
   localparam int LANES            = 3;

   // Tracker hold rules, in whole levels, and the liter count below which the fast weight applies.
   localparam int HOLD_MARGIN    = 5;
   localparam int MIN_HOLD_FLOOR = 10;
   localparam int MAX_HOLD_CEIL  = 2500;
   localparam int FAST_LITERS    = 2;

   localparam logic [PHASE_BITS-1:0] PHASE_LAST = PHASE_BITS'(PHASES_PER_LITER - 1);
   localparam logic signed [LITER_BITS-1:0] LITER_MAX = {1'b0, {(LITER_BITS-1){1'b1}}};

   // Register reset values.
   localparam logic [CSR_BITS-1:0] DARK_LIMIT_RESET   = CSR_BITS'(5);
   localparam logic [CSR_BITS-1:0] BRIGHT_LIMIT_RESET = CSR_BITS'(1500);
   localparam logic [CSR_BITS-1:0] ALPHA_SLOW_RESET   = CSR_BITS'(66);
   localparam logic [CSR_BITS-1:0] ALPHA_FAST_RESET   = CSR_BITS'(6554);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DARK_LIMIT   = 2'd0,
      CSR_BRIGHT_LIMIT = 2'd1,
      CSR_ALPHA_SLOW   = 2'd2,
      CSR_ALPHA_FAST   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_DECODED = 2'd0,
      STATUS_DARK    = 2'd1,
      STATUS_BRIGHT  = 2'd2,
      STATUS_INIT    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      EVENT_NONE     = 2'd0,
      EVENT_FORWARD  = 2'd1,
      EVENT_BACKWARD = 2'd2
   } event_type;

   // Control from the decoder to the tracker lanes.
   typedef struct packed {
      logic                   load;
      logic                   track;
      logic [WEIGHT_BITS-1:0] weight;
   } lane_ctl_type;

   // Wheel part of one result word.
   typedef struct packed {
      status_type                    status;
      logic [PHASE_BITS-1:0]         phase_now;
      logic signed [LITER_BITS-1:0]  liter_count;
      logic                          stepped;
      event_type                     liter_event;
   } wheel_result_type;

   // One complete result word.
   typedef struct packed {
      wheel_result_type                 wheel;
      logic [LANES-1:0][FIELD_BITS-1:0] min_level;
      logic [LANES-1:0][FIELD_BITS-1:0] max_level;
   } rsp_word_type;

endpackage
`default_nettype wire

>>> hw/rtl/tpofd_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tracker lane
// Minimum and maximum exponential-average trackers of one sensor channel.
// ----------------------------------------------------------------------------
module tpofd_lane
   import tpofd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lane_ctl_type           ctl,
   input  wire logic [LEVEL_BITS-1:0]  level,
   output logic [FIELD_BITS-1:0]       min_level,
   output logic [FIELD_BITS-1:0]       max_level
);

   localparam logic [TRACK_BITS:0] MARGIN_FIX =
      (TRACK_BITS+1)'(HOLD_MARGIN) << FRAC_BITS;
   localparam logic [WEIGHT_BITS:0] WEIGHT_ONE = (WEIGHT_BITS+1)'(1) << WEIGHT_BITS;
   localparam int SUM_BITS = TRACK_BITS + WEIGHT_BITS + 2;

   logic [TRACK_BITS-1:0] min_ff, min_in;
   logic [TRACK_BITS-1:0] max_ff, max_in;
   logic [TRACK_BITS-1:0] level_fix;
   logic [FIELD_BITS-1:0] level_wide;
   logic                  min_hold, max_hold;
   logic [WEIGHT_BITS:0]  keep_weight;
   logic [TRACK_BITS+WEIGHT_BITS:0] min_keep, max_keep;
   logic [LEVEL_BITS+WEIGHT_BITS-1:0] level_part;
   logic [SUM_BITS-1:0]   min_sum, max_sum;

   // The sample as a fixed-point value.
   assign level_fix  = {level, {FRAC_BITS{1'b0}}};
   assign level_wide = FIELD_BITS'(level);

   // Hold rules keep a tracker that is well clear of the sample.
   assign min_hold = (({1'b0, min_ff} + MARGIN_FIX) <= {1'b0, level_fix}) &&
                     (level_wide > FIELD_BITS'(MIN_HOLD_FLOOR));
   assign max_hold = ({1'b0, max_ff} >= ({1'b0, level_fix} + MARGIN_FIX)) &&
                     (level_wide < FIELD_BITS'(MAX_HOLD_CEIL));

   // Weighted blend of tracker and sample, truncated by the weight scale.
   assign keep_weight = WEIGHT_ONE - (WEIGHT_BITS+1)'(ctl.weight);
   assign min_keep    = keep_weight * min_ff;
   assign max_keep    = keep_weight * max_ff;
   assign level_part  = ctl.weight * level;
   assign min_sum = SUM_BITS'(min_keep) + (SUM_BITS'(level_part) << FRAC_BITS);
   assign max_sum = SUM_BITS'(max_keep) + (SUM_BITS'(level_part) << FRAC_BITS);

   // Next tracker values.
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (ctl.load) begin
         min_in = level_fix;
         max_in = '0;
      end else if (ctl.track) begin
         min_in = min_hold ? min_ff : TRACK_BITS'(min_sum >> WEIGHT_BITS);
         max_in = max_hold ? max_ff : TRACK_BITS'(max_sum >> WEIGHT_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= '0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // Integer parts after this sample.
   assign min_level = FIELD_BITS'(min_in >> FRAC_BITS);
   assign max_level = FIELD_BITS'(max_in >> FRAC_BITS);

endmodule
`default_nettype wire

>>> hw/rtl/tpofd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel decoder
// Sample checks, phase stepping, liter count and control of the lanes.
// ----------------------------------------------------------------------------
module tpofd_decode
   import tpofd_pkg::*;
(
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0]          csr_index,
   input  wire logic [CSR_BITS-1:0]                csr_data,
   input  wire logic                               accept,
   input  wire logic [LANES-1:0][FIELD_BITS-1:0]   levels,
   output lane_ctl_type                            ctl,
   output wheel_result_type                        result
);

   logic [CSR_BITS-1:0] dark_limit_ff, bright_limit_ff, alpha_slow_ff, alpha_fast_ff;
   logic                         init_ff, init_in;
   logic [PHASE_BITS-1:0]        phase_ff, phase_in;
   logic signed [LITER_BITS-1:0] liters_ff, liters_in;
   logic signed [LITER_BITS-1:0] liters_clamp;

   logic [FIELD_BITS-1:0]        lv [LANES];
   logic signed [DIFF_BITS-1:0]  lv_s [LANES];
   logic signed [DIFF_BITS-1:0]  diff [LANES];
   logic signed [DIFF_BITS-1:0]  sel_cur, sel_next, sel_prev;
   logic [1:0]                   idx_cur, idx_next, idx_prev;
   logic                         too_dark, too_bright, step, forward;

   // Used levels, zero-extended.
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         lv[k]   = FIELD_BITS'(levels[k][LEVEL_BITS-1:0]);
         lv_s[k] = DIFF_BITS'(levels[k][LEVEL_BITS-1:0]);
      end
   end

   // Range checks; the dark test takes precedence.
   assign too_dark   = (lv[0] < dark_limit_ff) || (lv[1] < dark_limit_ff) ||
                       (lv[2] < dark_limit_ff);
   assign too_bright = (lv[0] > bright_limit_ff) || (lv[1] > bright_limit_ff) ||
                       (lv[2] > bright_limit_ff);

   // Differential values; their sign follows the phase parity.
   always_comb begin
      diff[0] = (lv_s[0] <<< 1) - lv_s[1] - lv_s[2];
      diff[1] = (lv_s[1] <<< 1) - lv_s[0] - lv_s[2];
      diff[2] = (lv_s[2] <<< 1) - lv_s[0] - lv_s[1];
      if (!phase_ff[0]) begin
         for (int k = 0; k < LANES; k++) begin
            diff[k] = -diff[k];
         end
      end
   end

   // Rotation by phase modulo three.
   always_comb begin
      case (phase_ff)
         3'd0, 3'd3: idx_cur = 2'd0;
         3'd1, 3'd4: idx_cur = 2'd1;
         3'd2, 3'd5: idx_cur = 2'd2;
         default:    idx_cur = 2'd0;
      endcase
   end
   assign idx_next = (idx_cur == 2'd2) ? 2'd0 : idx_cur + 2'd1;
   assign idx_prev = (idx_cur == 2'd0) ? 2'd2 : idx_cur - 2'd1;
   assign sel_cur  = diff[idx_cur];
   assign sel_next = diff[idx_next];
   assign sel_prev = diff[idx_prev];

   assign step    = (sel_prev < sel_next) && (sel_prev < sel_cur);
   assign forward = sel_next > sel_cur;

   // Liters below zero restart at zero; the fast weight applies below two.
   assign liters_clamp = liters_ff[LITER_BITS-1] ? '0 : liters_ff;

   // Next wheel state and the result of this sample.
   always_comb begin
      init_in            = init_ff;
      phase_in           = phase_ff;
      liters_in          = liters_ff;
      ctl.load           = 1'b0;
      ctl.track          = 1'b0;
      ctl.weight         = (liters_ff < LITER_BITS'(FAST_LITERS)) ? alpha_fast_ff
                                                                 : alpha_slow_ff;
      result.status      = STATUS_DECODED;
      result.stepped     = 1'b0;
      result.liter_event = EVENT_NONE;
      if (too_dark) begin
         result.status = STATUS_DARK;
      end else if (too_bright) begin
         result.status = STATUS_BRIGHT;
      end else if (!init_ff) begin
         result.status = STATUS_INIT;
         init_in       = 1'b1;
         phase_in      = '0;
         liters_in     = '0;
         ctl.load      = accept;
      end else begin
         ctl.track = accept;
         liters_in = liters_clamp;
         if (step) begin
            result.stepped = 1'b1;
            if (forward) begin
               if (phase_ff == PHASE_LAST) begin
                  phase_in           = '0;
                  result.liter_event = EVENT_FORWARD;
                  if (liters_clamp != LITER_MAX) begin
                     liters_in = liters_clamp + LITER_BITS'(1);
                  end
               end else begin
                  phase_in = phase_ff + PHASE_BITS'(1);
               end
            end else begin
               if (phase_ff == '0) begin
                  phase_in           = PHASE_LAST;
                  result.liter_event = EVENT_BACKWARD;
                  liters_in          = liters_clamp - LITER_BITS'(1);
               end else begin
                  phase_in = phase_ff - PHASE_BITS'(1);
               end
            end
         end
      end
      result.phase_now   = phase_in;
      result.liter_count = liters_in;
   end

   // Configuration registers and wheel state.
   always_ff @(posedge clock) begin
      if (reset) begin
         dark_limit_ff   <= DARK_LIMIT_RESET;
         bright_limit_ff <= BRIGHT_LIMIT_RESET;
         alpha_slow_ff   <= ALPHA_SLOW_RESET;
         alpha_fast_ff   <= ALPHA_FAST_RESET;
         init_ff         <= 1'b0;
         phase_ff        <= '0;
         liters_ff       <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_DARK_LIMIT:   dark_limit_ff   <= csr_data;
               CSR_BRIGHT_LIMIT: bright_limit_ff <= csr_data;
               CSR_ALPHA_SLOW:   alpha_slow_ff   <= csr_data;
               CSR_ALPHA_FAST:   alpha_fast_ff   <= csr_data;
            endcase
         end
         if (accept) begin
            init_ff   <= init_in;
            phase_ff  <= phase_in;
            liters_ff <= liters_in;
         end
      end
   end

`ifndef SYNTHESIS
   // Before the first good sample the wheel state stays at its reset value.
   a_uninit_idle: assert property (@(posedge clock) disable iff (reset)
      !init_ff |-> (phase_ff == '0 && liters_ff == '0))
      else $error("wheel state moved before initialization");

   // The phase never leaves its range.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_LAST)
      else $error("phase out of range");

   // A liter only completes on a step.
   a_event_step: assert property (@(posedge clock) disable iff (reset)
      (accept && result.liter_event != EVENT_NONE) |-> result.stepped)
      else $error("liter event without a phase step");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/tpofd_obuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result buffer
// Output register with one skid word, so a stalled result does not block input until the skid word is full.
// ----------------------------------------------------------------------------
module tpofd_obuf
   import tpofd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_stall,
   input  wire rsp_word_type in_word,
   output logic              out_valid,
   input  wire logic         out_stall,
   output rsp_word_type      out_word
);

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type main_word_ff, main_word_in;
   rsp_word_type skid_word_ff, skid_word_in;
   logic         push, pop;

   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_word_ff;

   assign push = in_valid && !skid_valid_ff;
   assign pop  = main_valid_ff && !out_stall;

   // Word movement between input, skid and output register.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_word_in  = main_word_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_word_in  = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_word_in  = in_word;
            skid_valid_in = 1'b1;
         end else begin
            main_word_in  = in_word;
            main_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

`ifndef SYNTHESIS
   // The skid word only exists behind a full output register.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid word without output word");

   // A taken output word is replaced by the skid word at once.
   a_skid_moves: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !out_stall) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid word did not advance");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/three_phase_optical_flow_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Three-phase optical flow decoder
// Decodes meter wheel rotation from three light levels into phase and liters.
// ----------------------------------------------------------------------------
// One sample word is taken per clock while req_stall is low. All state (phase,
// liter count, six trackers) is updated in the cycle a sample is accepted,
// through three tracker lanes with three multipliers each and one wheel
// decoder, so a new sample may follow in every cycle that req_stall is low.
// Results are registered in an output register and a one-word skid buffer;
// req_stall rises only when both hold words that the consumer has not yet
// taken. The user writes configuration through csr_write, csr_index and csr_data
// while the block holds no pending work; the block does not enforce this.
module three_phase_optical_flow_decoder
   import tpofd_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [CSR_BITS-1:0]           csr_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [FIELD_BITS-1:0]         req_level_a,
   input  wire logic [FIELD_BITS-1:0]         req_level_b,
   input  wire logic [FIELD_BITS-1:0]         req_level_c,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [PHASE_BITS-1:0]              rsp_phase_now,
   output logic signed [LITER_BITS-1:0]       rsp_liter_count,
   output logic                               rsp_stepped,
   output logic [1:0]                         rsp_liter_event,
   output logic [FIELD_BITS-1:0]              rsp_min_a,
   output logic [FIELD_BITS-1:0]              rsp_min_b,
   output logic [FIELD_BITS-1:0]              rsp_min_c,
   output logic [FIELD_BITS-1:0]              rsp_max_a,
   output logic [FIELD_BITS-1:0]              rsp_max_b,
   output logic [FIELD_BITS-1:0]              rsp_max_c
);

   logic                             accept;
   logic [LANES-1:0][FIELD_BITS-1:0] levels;
   lane_ctl_type                     lane_ctl;
   rsp_word_type                     word, out_word;

   assign accept = req_valid && !req_stall;
   assign levels = {req_level_c, req_level_b, req_level_a};

   // Wheel decoder and configuration.
   tpofd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .levels    (levels),
      .ctl       (lane_ctl),
      .result    (word.wheel)
   );

   // One tracker lane per sensor.
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      tpofd_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (lane_ctl),
         .level     (levels[k][LEVEL_BITS-1:0]),
         .min_level (word.min_level[k]),
         .max_level (word.max_level[k])
      );
   end

   // Result buffer.
   tpofd_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_word   (word),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   assign rsp_status      = out_word.wheel.status;
   assign rsp_phase_now   = out_word.wheel.phase_now;
   assign rsp_liter_count = out_word.wheel.liter_count;
   assign rsp_stepped     = out_word.wheel.stepped;
   assign rsp_liter_event = out_word.wheel.liter_event;
   assign rsp_min_a       = out_word.min_level[0];
   assign rsp_min_b       = out_word.min_level[1];
   assign rsp_min_c       = out_word.min_level[2];
   assign rsp_max_a       = out_word.max_level[0];
   assign rsp_max_b       = out_word.max_level[1];
   assign rsp_max_c       = out_word.max_level[2];

endmodule
`default_nettype wire

>>> tb/sv/three_phase_optical_flow_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-phase optical flow decoder testbench
// Drives light-level sample words into the decoder and checks every result
// word against a cycle-free model of the wheel decoder and the six trackers.
// Stimulus is a short directed set, then rotating three-phase sweeps mixed
// with noise, run under several register settings and handshake patterns.
// ----------------------------------------------------------------------------
module three_phase_optical_flow_decoder_test;
   import tpofd_pkg::*;

   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES = 4;
   localparam logic signed [LITER_BITS-1:0] LITER_MIN = {1'b1, {(LITER_BITS-1){1'b0}}};

   typedef struct packed {
      logic [FIELD_BITS-1:0] level_a;
      logic [FIELD_BITS-1:0] level_b;
      logic [FIELD_BITS-1:0] level_c;
   } sample_type;

   // Block ports.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   csr_index_type csr_index = CSR_DARK_LIMIT;
   logic [CSR_BITS-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [FIELD_BITS-1:0] req_level_a = '0;
   logic [FIELD_BITS-1:0] req_level_b = '0;
   logic [FIELD_BITS-1:0] req_level_c = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [PHASE_BITS-1:0] rsp_phase_now;
   logic signed [LITER_BITS-1:0] rsp_liter_count;
   logic rsp_stepped;
   logic [1:0] rsp_liter_event;
   logic [FIELD_BITS-1:0] rsp_min_a;
   logic [FIELD_BITS-1:0] rsp_min_b;
   logic [FIELD_BITS-1:0] rsp_min_c;
   logic [FIELD_BITS-1:0] rsp_max_a;
   logic [FIELD_BITS-1:0] rsp_max_b;
   logic [FIELD_BITS-1:0] rsp_max_c;

   // Register shadows.
   logic [CSR_BITS-1:0] dark_cfg = DARK_LIMIT_RESET;
   logic [CSR_BITS-1:0] bright_cfg = BRIGHT_LIMIT_RESET;
   logic [CSR_BITS-1:0] alpha_slow_cfg = ALPHA_SLOW_RESET;
   logic [CSR_BITS-1:0] alpha_fast_cfg = ALPHA_FAST_RESET;

   // Decoder state as the testbench sees it.
   logic wheel_ready = 1'b0;
   logic [PHASE_BITS-1:0] wheel_phase = '0;
   logic signed [LITER_BITS-1:0] liter_total = '0;
   logic [TRACK_BITS-1:0] min_track [LANES] = '{default: '0};
   logic [TRACK_BITS-1:0] max_track [LANES] = '{default: '0};

   // Traffic bookkeeping.
   sample_type pending_samples [$];
   rsp_word_type expected_words [$];
   int mismatch_count = 0;
   logic req_taken = 1'b0;
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int preferred_dir = 1;
   real wheel_angle = 0.0;
   logic hold_request = 1'b0;
   logic rsp_hold = 1'b0;

   three_phase_optical_flow_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_level_a     (req_level_a),
      .req_level_b     (req_level_b),
      .req_level_c     (req_level_c),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_phase_now   (rsp_phase_now),
      .rsp_liter_count (rsp_liter_count),
      .rsp_stepped     (rsp_stepped),
      .rsp_liter_event (rsp_liter_event),
      .rsp_min_a       (rsp_min_a),
      .rsp_min_b       (rsp_min_b),
      .rsp_min_c       (rsp_min_c),
      .rsp_max_a       (rsp_max_a),
      .rsp_max_b       (rsp_max_b),
      .rsp_max_c       (rsp_max_c)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Exponential average of a tracker toward the new level, truncated.
   function automatic logic [TRACK_BITS-1:0] blend(logic [TRACK_BITS-1:0] x, logic [63:0] y,
                                                   logic [CSR_BITS-1:0] w);
      logic [63:0] sum;
      sum = (64'd65536 - 64'(w)) * 64'(x) + 64'(w) * y;
      return sum[47:16];
   endfunction

   // The minimum tracker holds while the level sits well above it.
   function automatic logic [TRACK_BITS-1:0] track_min(logic [TRACK_BITS-1:0] x,
                                                       logic [FIELD_BITS-1:0] lvl,
                                                       logic [CSR_BITS-1:0] w);
      logic [63:0] y;
      logic [63:0] margin;
      y = 64'(lvl) << FRAC_BITS;
      margin = 64'(HOLD_MARGIN) << FRAC_BITS;
      if (64'(x) + margin <= y && lvl > MIN_HOLD_FLOOR) return x;
      return blend(x, y, w);
   endfunction

   // The maximum tracker holds while the level sits well below it.
   function automatic logic [TRACK_BITS-1:0] track_max(logic [TRACK_BITS-1:0] x,
                                                       logic [FIELD_BITS-1:0] lvl,
                                                       logic [CSR_BITS-1:0] w);
      logic [63:0] y;
      logic [63:0] margin;
      y = 64'(lvl) << FRAC_BITS;
      margin = 64'(HOLD_MARGIN) << FRAC_BITS;
      if (64'(x) >= y + margin && lvl < MAX_HOLD_CEIL) return x;
      return blend(x, y, w);
   endfunction

   // Advances the decoder state by one sample and returns its result word.
   function automatic rsp_word_type decode_sample(sample_type s);
      rsp_word_type word;
      logic [FIELD_BITS-1:0] lv [LANES];
      logic [CSR_BITS-1:0] w;
      int d [LANES];
      int a, b, c, ph, i, j1, j2;
      status_type st;
      event_type ev;
      logic moved;
      lv[0] = s.level_a;
      lv[1] = s.level_b;
      lv[2] = s.level_c;
      st = STATUS_DECODED;
      ev = EVENT_NONE;
      moved = 1'b0;
      if (lv[0] < dark_cfg || lv[1] < dark_cfg || lv[2] < dark_cfg) begin
         st = STATUS_DARK;
      end else if (lv[0] > bright_cfg || lv[1] > bright_cfg || lv[2] > bright_cfg) begin
         st = STATUS_BRIGHT;
      end else if (!wheel_ready) begin
         // The first good sample seeds the minimums and clears everything else.
         wheel_ready = 1'b1;
         wheel_phase = '0;
         liter_total = '0;
         for (int k = 0; k < LANES; k++) begin
            min_track[k] = TRACK_BITS'(lv[k]) << FRAC_BITS;
            max_track[k] = '0;
         end
         st = STATUS_INIT;
      end else begin
         w = alpha_slow_cfg;
         if (liter_total < FAST_LITERS) begin
            w = alpha_fast_cfg;
            if (liter_total < 0) liter_total = '0;
         end
         for (int k = 0; k < LANES; k++) begin
            min_track[k] = track_min(min_track[k], lv[k], w);
            max_track[k] = track_max(max_track[k], lv[k], w);
         end

         // Differentials, sign flipped on even phases.
         a = lv[0];
         b = lv[1];
         c = lv[2];
         d[0] = 2 * a - b - c;
         d[1] = 2 * b - a - c;
         d[2] = 2 * c - a - b;
         if (!wheel_phase[0]) begin
            for (int k = 0; k < LANES; k++) d[k] = -d[k];
         end

         // Step only when the trailing value is strictly the least.
         i = wheel_phase % 3;
         j1 = (i + 1) % 3;
         j2 = (i + 2) % 3;
         ph = wheel_phase;
         if (d[j2] < d[j1] && d[j2] < d[i]) begin
            moved = 1'b1;
            if (d[j1] > d[i]) ph++;
            else ph--;
         end

         // Wrapping the phase counts a liter, saturating at the signed limits.
         if (ph >= PHASES_PER_LITER) begin
            ph = 0;
            ev = EVENT_FORWARD;
            if (liter_total != LITER_MAX) liter_total++;
         end else if (ph < 0) begin
            ph = PHASES_PER_LITER - 1;
            ev = EVENT_BACKWARD;
            if (liter_total != LITER_MIN) liter_total--;
         end
         wheel_phase = PHASE_BITS'(ph);
      end

      word.wheel.status = st;
      word.wheel.phase_now = wheel_phase;
      word.wheel.liter_count = liter_total;
      word.wheel.stepped = moved;
      word.wheel.liter_event = ev;
      for (int k = 0; k < LANES; k++) begin
         word.min_level[k] = min_track[k][TRACK_BITS-1:FRAC_BITS];
         word.max_level[k] = max_track[k][TRACK_BITS-1:FRAC_BITS];
      end
      return word;
   endfunction

   // Compares one result field and reports the first few differences.
   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         if (mismatch_count < 10)
            $display("%0t: field %s differs: expected %0h, got %0h", $realtime, name, want, got);
         mismatch_count++;
      end
   endtask

   // A level near the current limits, or any 16-bit value.
   function automatic logic [FIELD_BITS-1:0] noise_level();
      case ($urandom_range(5))
         0: return dark_cfg - 16'd1;
         1: return dark_cfg;
         2: return bright_cfg;
         3: return bright_cfg + 16'd1;
         default: return FIELD_BITS'($urandom);
      endcase
   endfunction

   function automatic void push_levels(logic [FIELD_BITS-1:0] a, logic [FIELD_BITS-1:0] b,
                                       logic [FIELD_BITS-1:0] c);
      sample_type s;
      s.level_a = a;
      s.level_b = b;
      s.level_c = c;
      pending_samples.push_back(s);
   endfunction

   function automatic int push_noise(int len);
      for (int n = 0; n < len; n++) push_levels(noise_level(), noise_level(), noise_level());
      return len;
   endfunction

   // A run of samples from a turning wheel: three cosines 120 degrees apart
   // that stay inside the current limits, with an occasional spike.
   function automatic int push_sweep(int len);
      int span, amp, center, dir, stride;
      logic [FIELD_BITS-1:0] lv [LANES];
      span = int'(bright_cfg) - int'(dark_cfg);
      if (span < 40) return push_noise(len);
      amp = span * int'($urandom_range(5, 45)) / 100;
      center = int'(dark_cfg) + amp + int'($urandom_range(span - 2 * amp));
      dir = ($urandom_range(99) < 75) ? preferred_dir : -preferred_dir;
      for (int n = 0; n < len; n++) begin
         stride = $urandom_range(5, 45);
         wheel_angle += dir * stride;
         for (int k = 0; k < LANES; k++)
            lv[k] = FIELD_BITS'($rtoi(real'(center) + real'(amp) *
                    $cos((wheel_angle - 120.0 * k) * 3.14159265358979 / 180.0)));
         if ($urandom_range(99) < 3) lv[$urandom_range(2)] = noise_level();
         push_levels(lv[0], lv[1], lv[2]);
      end
      return len;
   endfunction

   // Mostly well-formed sweeps, the rest bursts of noise.
   task automatic push_random(int count);
      int pushed;
      pushed = 0;
      while (pushed < count) begin
         if ($urandom_range(99) < 80) pushed += push_sweep($urandom_range(10, 60));
         else pushed += push_noise($urandom_range(1, 5));
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_BITS-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         CSR_DARK_LIMIT: dark_cfg = value;
         CSR_BRIGHT_LIMIT: bright_cfg = value;
         CSR_ALPHA_SLOW: alpha_slow_cfg = value;
         CSR_ALPHA_FAST: alpha_fast_cfg = value;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_all_csr(logic [CSR_BITS-1:0] dark, logic [CSR_BITS-1:0] bright,
                                logic [CSR_BITS-1:0] slow, logic [CSR_BITS-1:0] fast);
      write_csr(CSR_DARK_LIMIT, dark);
      write_csr(CSR_BRIGHT_LIMIT, bright);
      write_csr(CSR_ALPHA_SLOW, slow);
      write_csr(CSR_ALPHA_FAST, fast);
   endtask

   task automatic start_phase(int idle, int stall, int dir);
      @(posedge clock);
      sender_idle_pct = idle;
      stall_pct = stall;
      preferred_dir = dir;
   endtask

   // Waits until every offered word has come back, plus the pipeline depth.
   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Sender: holds a word until it is taken, then maybe idles.
   always @(negedge clock) begin
      sample_type next_sample;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_sample = pending_samples.pop_front();
            req_valid <= 1'b1;
            req_level_a <= next_sample.level_a;
            req_level_b <= next_sample.level_b;
            req_level_c <= next_sample.level_c;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, forced high during the long hold-off.
   always @(negedge clock) begin
      rsp_stall <= !reset && (rsp_hold || $urandom_range(99) < stall_pct);
   end

   // Long hold-off of the receiver while the sender keeps offering words.
   initial begin
      wait (hold_request);
      repeat (HOLD_CYCLES) @(negedge clock) rsp_hold <= 1'b1;
      @(negedge clock) rsp_hold <= 1'b0;
   end

   // Checks each result word, then records the sample word taken at this edge.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: result word with nothing pending", $realtime);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("status", want.wheel.status, rsp_status);
               check_field("phase_now", want.wheel.phase_now, rsp_phase_now);
               check_field("liter_count", want.wheel.liter_count, rsp_liter_count);
               check_field("stepped", want.wheel.stepped, rsp_stepped);
               check_field("liter_event", want.wheel.liter_event, rsp_liter_event);
               check_field("min_a", want.min_level[0], rsp_min_a);
               check_field("min_b", want.min_level[1], rsp_min_b);
               check_field("min_c", want.min_level[2], rsp_min_c);
               check_field("max_a", want.max_level[0], rsp_max_a);
               check_field("max_b", want.max_level[1], rsp_max_b);
               check_field("max_c", want.max_level[2], rsp_max_c);
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken)
            expected_words.push_back(decode_sample({req_level_a, req_level_b, req_level_c}));
      end
   end

   // Phases of stimulus under different register settings.
   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Reset settings, no idling, with the long hold-off.
      start_phase(0, 0, 1);
      push_levels(16'd0, 16'd0, 16'd0);
      push_levels(16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_levels(16'd4, 16'd700, 16'd700);
      push_levels(16'd700, 16'd1501, 16'd700);
      push_levels(16'd3, 16'd1600, 16'd700);
      push_levels(16'd5, 16'd1500, 16'd800);
      push_levels(16'd800, 16'd800, 16'd800);
      push_levels(16'd1500, 16'd5, 16'd5);
      void'(push_sweep(10));
      hold_request = 1'b1;
      push_random(270);
      wait_drained();

      // Widest limits and extreme weights; sender idles.
      write_all_csr(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
      start_phase(55, 0, -1);
      push_levels(16'd10, 16'd11, 16'd12);
      push_levels(16'd2499, 16'd2500, 16'd2501);
      push_levels(16'hFFFF, 16'd0, 16'hFFFF);
      push_levels(16'd0, 16'd0, 16'd0);
      push_random(270);
      wait_drained();

      // Middle settings; receiver stalls.
      write_all_csr(16'd100, 16'd4000, 16'd1000, 16'd20000);
      start_phase(0, 55, 1);
      push_random(270);
      wait_drained();

      // Inverted limits reject every sample.
      write_all_csr(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
      start_phase(0, 0, 1);
      push_levels(16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_random(40);
      wait_drained();

      // Back to the reset settings; both sides idle now and then.
      write_all_csr(DARK_LIMIT_RESET, BRIGHT_LIMIT_RESET, ALPHA_SLOW_RESET, ALPHA_FAST_RESET);
      start_phase(10, 10, -1);
      push_random(200);
      wait_drained();

      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("three_phase_optical_flow_decoder: match");
      else
         $display("three_phase_optical_flow_decoder: mismatch");
      $finish;
   end

   // Watchdog.
   initial begin
      #10_000_000;
      $display("three_phase_optical_flow_decoder: mismatch");
      $finish;
   end

endmodule
